/* sv/prnc_pkg.sv */
// ----------------------------------------------------------------------------
// prnc_pkg
// Shared constants, codes and controller/datapath interface types for the
// NRU / clock page replacement block.
// ----------------------------------------------------------------------------
package prnc_pkg;

  // page table geometry
  localparam int PAGES   = 128;
  localparam int PAGE_AW = $clog2(PAGES);
  localparam int STEP_W  = $clog2(2 * PAGES);
  localparam int FLAG_W  = 3;

  // field widths
  localparam int PAGE_W     = 7;
  localparam int CNT_W      = 32;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;

  // flag bit positions and masks
  localparam int FLAG_P = 0;
  localparam int FLAG_R = 1;
  localparam int FLAG_M = 2;
  localparam logic [FLAG_W-1:0] F_P = 3'b001;
  localparam logic [FLAG_W-1:0] F_R = 3'b010;
  localparam logic [FLAG_W-1:0] F_M = 3'b100;

  // item modes
  localparam logic [IN_USER_W-1:0] MODE_ACCESS = 2'd0;
  localparam logic [IN_USER_W-1:0] MODE_CLEAR  = 2'd1;
  localparam logic [IN_USER_W-1:0] MODE_LOAD   = 2'd2;

  // policy codes
  localparam logic POLICY_NRU   = 1'b0;
  localparam logic POLICY_CLOCK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_NRU_PICK,
    ST_FINISH,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RD_INPUT,
    RD_ZERO,
    RD_HAND,
    RD_NEXT
  } rd_src_t;

  typedef struct packed {
    logic    latch;
    logic    capture_old;
    logic    set_hit;
    logic    miss_inc;
    logic    wr_update;
    logic    wr_load;
    logic    scan_step;
    logic    clear_step;
    logic    nru_pick;
    logic    finish;
    logic    load_out;
    rd_src_t rd_src;
  } dp_cmd_t;

  typedef struct packed {
    logic [IN_USER_W-1:0] mode;
    logic                 page_ok;
    logic                 present;
    logic                 policy;
    logic                 found;
    logic                 scan_end;
    logic                 cur_last;
    logic                 out_free;
  } dp_status_t;

endpackage

/* sv/prnc_ram.sv */
// ----------------------------------------------------------------------------
// prnc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module prnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/prnc_ctrl.sv */
// ----------------------------------------------------------------------------
// prnc_ctrl
// Sequencer for the page replacement block: lookup, victim scan, reference
// clear sweep and result hand-off.
// ----------------------------------------------------------------------------
module prnc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  prnc_pkg::dp_status_t status,
  output prnc_pkg::dp_cmd_t    cmd
);
  import prnc_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.rd_src    = RD_NEXT;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        cmd.rd_src    = RD_INPUT;
        if (s_axis_tvalid && !rst) begin
          cmd.latch  = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.capture_old = 1'b1;
        if (status.mode == MODE_ACCESS && status.page_ok) begin
          if (status.present) begin
            cmd.set_hit   = 1'b1;
            cmd.wr_update = 1'b1;
            state_next    = ST_RESULT;
          end else begin
            cmd.miss_inc = 1'b1;
            cmd.rd_src   = (status.policy == POLICY_CLOCK) ? RD_HAND : RD_ZERO;
            state_next   = ST_SCAN;
          end
        end else if (status.mode == MODE_CLEAR) begin
          cmd.rd_src = RD_ZERO;
          state_next = ST_CLEAR;
        end else if (status.mode == MODE_LOAD && status.page_ok) begin
          cmd.wr_load = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.found) begin
          state_next = ST_FINISH;
        end else if (status.scan_end) begin
          state_next = (status.policy == POLICY_CLOCK) ? ST_FINISH : ST_NRU_PICK;
        end
      end
      ST_NRU_PICK: begin
        cmd.nru_pick = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.wr_update = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = ST_RESULT;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.cur_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/prnc_dp.sv */
// ----------------------------------------------------------------------------
// prnc_dp
// Datapath: page flag RAM with valid bits, clock hand, NRU class trackers,
// saturating counters, policy register and the output register.
// ----------------------------------------------------------------------------
module prnc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  prnc_pkg::dp_cmd_t                    cmd,
  output prnc_pkg::dp_status_t                 status,
  input  logic [prnc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic [prnc_pkg::IN_USER_W-1:0]       s_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [prnc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import prnc_pkg::*;

  // latched item
  logic [IN_USER_W-1:0] mode_q;
  logic [PAGE_W-1:0]    page_q;
  logic                 wr_q;
  logic [FLAG_W-1:0]    load_q;
  logic [FLAG_W-1:0]    old_q;

  // result and state
  logic               hit_q;
  logic               vvalid_q;
  logic [PAGE_AW-1:0] vpage_q;
  logic               vdirty_q;
  logic [PAGE_AW-1:0] hand;
  logic [CNT_W-1:0]   miss_cnt;
  logic [CNT_W-1:0]   acc_cnt;
  logic               policy;
  logic [STEP_W-1:0]  step;
  logic [PAGE_AW-1:0] cur;
  logic [PAGES-1:0]   vld;

  // nru class trackers, classes one to three
  logic [PAGE_AW-1:0] last1, last2, last3;
  logic               ok1, ok2, ok3;

  // ram ports
  logic               we;
  logic [PAGE_AW-1:0] waddr;
  logic [FLAG_W-1:0]  wdata;
  logic [PAGE_AW-1:0] raddr;
  logic [FLAG_W-1:0]  ram_q;

  logic [PAGE_AW-1:0] pidx;
  logic [PAGE_AW-1:0] cur_inc;
  logic [FLAG_W-1:0]  f;
  logic [FLAG_W-1:0]  upd_base;
  logic               found;
  logic               nru_any;
  logic [PAGE_AW-1:0] nru_ix;
  logic               nru_dirty;
  logic [CNT_W:0]     acc_sum;

  prnc_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (PAGES)
  ) u_flags (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign cfg_ready = 1'b1;
  assign pidx      = PAGE_AW'(page_q);
  assign cur_inc   = (cur == PAGE_AW'(PAGES - 1)) ? '0 : cur + 1'b1;

  // never-written entries read as cleared flags
  assign f        = vld[cur] ? ram_q : '0;
  assign upd_base = cmd.capture_old ? f : old_q;

  // victim test: clock takes any present unreferenced page, nru only class zero
  assign found = (policy == POLICY_CLOCK) ? (f[FLAG_P] && !f[FLAG_R])
                                          : (f[FLAG_P] && !f[FLAG_R] && !f[FLAG_M]);

  // nru fallback: last page of the lowest non-empty class
  always_comb begin
    nru_any   = 1'b1;
    nru_ix    = last3;
    nru_dirty = 1'b1;
    if (ok1) begin
      nru_ix    = last1;
      nru_dirty = 1'b1;
    end else if (ok2) begin
      nru_ix    = last2;
      nru_dirty = 1'b0;
    end else if (!ok3) begin
      nru_any = 1'b0;
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_src)
      RD_INPUT: raddr = PAGE_AW'(s_axis_tdata[PAGE_W-1:0]);
      RD_ZERO:  raddr = '0;
      RD_HAND:  raddr = hand;
      RD_NEXT:  raddr = cur_inc;
      default:  raddr = cur_inc;
    endcase
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = '0;
    if (cmd.wr_update) begin
      we    = 1'b1;
      waddr = pidx;
      wdata = upd_base | F_P | F_R | (wr_q ? F_M : '0);
    end else if (cmd.wr_load) begin
      we    = 1'b1;
      waddr = pidx;
      wdata = load_q;
    end else if (cmd.scan_step) begin
      if (found) begin
        we = 1'b1;
      end else if (f[FLAG_P] && policy == POLICY_CLOCK) begin
        we    = 1'b1;
        wdata = f & ~F_R;
      end
    end else if (cmd.clear_step) begin
      we    = 1'b1;
      wdata = f & ~F_R;
    end else if (cmd.nru_pick) begin
      we    = nru_any;
      waddr = nru_ix;
    end
  end

  assign acc_sum = {1'b0, acc_cnt} + (vdirty_q ? (CNT_W + 1)'(2) : (CNT_W + 1)'(1));

  // status to the controller
  always_comb begin
    status.mode     = mode_q;
    status.page_ok  = 32'(page_q) < 32'(PAGES);
    status.present  = f[FLAG_P];
    status.policy   = policy;
    status.found    = found;
    status.scan_end = (policy == POLICY_CLOCK) ? (step == STEP_W'(2 * PAGES - 1))
                                               : (step == STEP_W'(PAGES - 1));
    status.cur_last = cur == PAGE_AW'(PAGES - 1);
    status.out_free = !m_axis_tvalid || m_axis_tready;
  end

  // read address tracking, item latch and result payload
  always_ff @(posedge clk) begin
    cur <= raddr;
    if (cmd.latch) begin
      mode_q   <= s_axis_tuser;
      page_q   <= s_axis_tdata[PAGE_W-1:0];
      wr_q     <= s_axis_tdata[PAGE_W];
      load_q   <= {s_axis_tdata[PAGE_W+3], s_axis_tdata[PAGE_W+2], s_axis_tdata[PAGE_W+1]};
      hit_q    <= 1'b0;
      vvalid_q <= 1'b0;
      vpage_q  <= '0;
      vdirty_q <= 1'b0;
      step     <= '0;
    end
    if (cmd.capture_old) begin
      old_q <= f;
    end
    if (cmd.set_hit) begin
      hit_q <= 1'b1;
    end
    if (cmd.scan_step) begin
      step <= step + 1'b1;
      if (found) begin
        vvalid_q <= 1'b1;
        vpage_q  <= cur;
        vdirty_q <= f[FLAG_M];
      end else if (policy == POLICY_NRU && f[FLAG_P]) begin
        case ({f[FLAG_R], f[FLAG_M]})
          2'b01:   last1 <= cur;
          2'b10:   last2 <= cur;
          default: last3 <= cur;
        endcase
      end
    end
    if (cmd.nru_pick && nru_any) begin
      vvalid_q <= 1'b1;
      vpage_q  <= nru_ix;
      vdirty_q <= nru_dirty;
    end
    if (cmd.load_out) begin
      m_axis_tdata <= {6'd0, acc_cnt, miss_cnt, vdirty_q, PAGE_W'(vpage_q), vvalid_q, hit_q};
    end
  end

  // control state: flags valid, hand, counters, policy, class marks, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      hand          <= '0;
      miss_cnt      <= '0;
      acc_cnt       <= '0;
      policy        <= POLICY_CLOCK;
      ok1           <= 1'b0;
      ok2           <= 1'b0;
      ok3           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (cfg_valid) begin
        policy <= cfg_data;
      end
      if (cmd.latch) begin
        ok1 <= 1'b0;
        ok2 <= 1'b0;
        ok3 <= 1'b0;
      end
      if (cmd.scan_step && !found && policy == POLICY_NRU && f[FLAG_P]) begin
        case ({f[FLAG_R], f[FLAG_M]})
          2'b01:   ok1 <= 1'b1;
          2'b10:   ok2 <= 1'b1;
          default: ok3 <= 1'b1;
        endcase
      end
      if (cmd.scan_step && found && policy == POLICY_CLOCK) begin
        hand <= cur;
      end
      if (cmd.miss_inc && miss_cnt != '1) begin
        miss_cnt <= miss_cnt + 1'b1;
      end
      if (cmd.finish && vvalid_q) begin
        acc_cnt <= acc_sum[CNT_W] ? '1 : acc_sum[CNT_W-1:0];
      end
      if (cmd.load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* sv/page_replacement_nru_clock.sv */
// Sequence: hit, load and unused modes go from accept via lookup to the result; a miss
// adds a scan (clock: up to two passes from the hand; NRU: up to one pass from entry 0
// plus a class pick if no victim is found), then a finish; a clear visits every entry.
// Flow: one item at a time, next accept in the cycle after the result is loaded;
// the flag RAM port visits one entry per cycle and sets the scan length.
// Reset: flags read as clear through per-entry valid bits, no clearing pass; policy 1.
// ----------------------------------------------------------------------------
// page_replacement_nru_clock
// Page flag tracker with NRU class or clock second chance victim selection.
// ----------------------------------------------------------------------------
module page_replacement_nru_clock (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: page_number[6:0], is_write, load_present, load_referenced, load_modified
  input  logic [prnc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [prnc_pkg::IN_USER_W-1:0]      s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: hit, victim_valid, victim_page[6:0], victim_dirty, miss_total[31:0],
  //        access_total[31:0], zero pad
  output logic [prnc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);
  import prnc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  prnc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // flag store and result datapath
  prnc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* sv/prnc_checker.sv */
// ----------------------------------------------------------------------------
// prnc_checker
// Port-level checks for the page replacement block, bound to the top level.
// ----------------------------------------------------------------------------
module prnc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [prnc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready
);
  import prnc_pkg::*;

  // one item in flight: no accept right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a hit never evicts
  a_hit_no_victim: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit reported together with a victim");

  // victim page and dirty flag are zero without a victim
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[9:2] == 8'd0))
    else $error("victim fields set without a victim");

endmodule

bind page_replacement_nru_clock prnc_checker u_checker (.*);
